FILE: sv/gcss_pkg.sv
// Shared types, widths and constants for the gradient clamp span splitter.
// No dependencies; every other file of the block imports this package.
package gcss_pkg;

   localparam int SPAN_W       = 13;
   localparam int SPAN_MAX     = (1 << SPAN_W) - 1;
   localparam int MAX_SPAN_DEF = 4096;
   localparam int POS_W        = 32;
   localparam int VAL_W        = 32;
   localparam int NUM_W        = 34;                  // divider numerator / remainder
   localparam int DEN_W        = 32;                  // |step|, up to 2^31
   localparam int CMP_W        = DEN_W + SPAN_W + 2;  // room for den << quotient bit
   localparam int LANES        = 3;

   // divider lanes: count of pixels below each threshold
   localparam int LANE_LO  = 0;   // low clamp edge
   localparam int LANE_HI  = 1;   // high clamp edge
   localparam int LANE_LIM = 2;   // 16.16 range limit

   typedef enum logic [2:0] {
      CLASS_NONE  = 3'd0,
      CLASS_LOW   = 3'd1,
      CLASS_MID   = 3'd2,
      CLASS_HIGH  = 3'd3,
      CLASS_SPLIT = 3'd4
   } run_class_type;

   typedef struct packed {
      logic signed [POS_W-1:0] start_pos;
      logic signed [POS_W-1:0] step_size;
      logic [SPAN_W-1:0]       span_len;
      logic [VAL_W-1:0]        value_first;
      logic [VAL_W-1:0]        value_second;
   } req_type;

   typedef struct packed {
      logic [SPAN_W-1:0]       run_low;
      logic [SPAN_W-1:0]       run_mid;
      logic [SPAN_W-1:0]       run_high;
      logic signed [POS_W-1:0] mid_start;
      logic [VAL_W-1:0]        end_value_a;
      logic [VAL_W-1:0]        end_value_b;
      logic                    overflow_flag;
   } rsp_type;

   typedef struct packed {
      run_class_type           run_class;
      logic                    neg;
      logic                    ovf;
      logic [SPAN_W-1:0]       n;
      logic signed [POS_W-1:0] fx0;
      logic signed [POS_W-1:0] dx;
      logic [VAL_W-1:0]        va;
      logic [VAL_W-1:0]        vb;
   } ctx_type;

   typedef struct packed {
      logic [NUM_W-1:0]  rem;
      logic [SPAN_W-1:0] quo;
      logic              sat;
   } lane_type;

   typedef struct packed {
      ctx_type                    ctx;
      logic [DEN_W-1:0]           den;
      lane_type [LANES-1:0]       lane;
   } work_type;

   // quotient bits needed to reach the largest span length
   function automatic int quo_width(input int max_span);
      int top;
      top = (max_span < SPAN_MAX) ? max_span : SPAN_MAX;
      return $clog2(top + 1);
   endfunction

endpackage

FILE: sv/gradient_clamp_span_split_top.sv
// Top level of the gradient clamp span splitter: front end, divider cell
// row and back end. Depends on gcss_pkg, gcss_prep, gcss_div_cell, gcss_post.
//
// Splits one 16.16 gradient span per item into a leading clamped run, an
// unclamped middle run and a trailing clamped run, with the start position
// of the middle run, the end values (swapped for a split span with a
// negative step) and a flag for spans that leave the 16.16 range. The
// block takes one item per clock unless the result side stalls, and returns
// one result item per input item, in order. It has three front-end stages
// (length saturation and n*step, end positions, classification and divider
// setup), one cell per quotient bit in the divider row, with QW quotient
// bits where QW = clog2(min(MAX_SPAN, 8191) + 1), and two back-end stages
// (run assembly and the result register). The divider row computes three
// ceil-divides side by side, one per lane: pixels below the low edge, below
// the high edge and below the 16.16 limit. Each cell settles one quotient
// bit of all three lanes and passes the item on to the next cell. Every
// stage holds its item only while the next one is full and stalled, so a
// waiting result does not keep new items out until the whole row is full.
module gradient_clamp_span_split_top #(
   parameter int MAX_SPAN = gcss_pkg::MAX_SPAN_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  gcss_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output gcss_pkg::rsp_type rsp_data
);
   import gcss_pkg::*;

   localparam int QW = quo_width(MAX_SPAN);

   // item hand-off along the divider row; index 0 is the front end output
   work_type  chain_data [QW+1];
   logic [QW:0] chain_valid;
   logic [QW:0] chain_ready;

   gcss_prep #(
      .MAX_SPAN(MAX_SPAN)
   ) u_prep (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_ready  (req_ready),
      .in_data   (req_data),
      .out_valid (chain_valid[0]),
      .out_ready (chain_ready[0]),
      .out_data  (chain_data[0])
   );

   // most significant quotient bit first
   for (genvar s = 0; s < QW; s++) begin : g_div
      gcss_div_cell #(
         .BIT(QW - 1 - s)
      ) u_div_cell (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (chain_valid[s]),
         .in_ready  (chain_ready[s]),
         .in_data   (chain_data[s]),
         .out_valid (chain_valid[s+1]),
         .out_ready (chain_ready[s+1]),
         .out_data  (chain_data[s+1])
      );
   end

   gcss_post u_post (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (chain_valid[QW]),
      .in_ready  (chain_ready[QW]),
      .in_data   (chain_data[QW]),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .out_data  (rsp_data)
   );

endmodule

FILE: sv/gcss_prep.sv
// Front end: span length saturation, end positions, classification and
// divider operand setup (three pipeline stages). Depends on gcss_pkg.
module gcss_prep #(
   parameter int MAX_SPAN = gcss_pkg::MAX_SPAN_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  gcss_pkg::req_type in_data,
   output logic              out_valid,
   input  logic              out_ready,
   output gcss_pkg::work_type out_data
);
   import gcss_pkg::*;

   localparam int QW     = quo_width(MAX_SPAN);
   localparam int PROD_W = 46;
   localparam int A_W    = 34;
   localparam int CALC_W = 36;
   localparam longint FIX_MAX = 64'sh7FFF_FFFF;
   localparam longint EDGE_HI = 64'sh0000_FFFF;
   localparam logic signed [A_W-1:0] THR_LO_POS = '0;
   localparam logic signed [A_W-1:0] THR_LO_NEG = A_W'(1 - EDGE_HI);
   localparam logic signed [A_W-1:0] THR_HI_POS = A_W'(EDGE_HI);
   localparam logic signed [A_W-1:0] THR_HI_NEG = A_W'(1);
   localparam logic signed [A_W-1:0] THR_LIM    = A_W'(FIX_MAX);

   typedef struct packed {
      logic [SPAN_W-1:0]        n;
      logic signed [POS_W-1:0]  fx0;
      logic signed [POS_W-1:0]  dx;
      logic [VAL_W-1:0]         va;
      logic [VAL_W-1:0]         vb;
      logic signed [PROD_W-1:0] prod;
   } sa_type;

   typedef struct packed {
      logic [SPAN_W-1:0]       n;
      logic signed [POS_W-1:0] fx0;
      logic signed [POS_W-1:0] dx;
      logic [VAL_W-1:0]        va;
      logic [VAL_W-1:0]        vb;
      logic                    fx_le0;
      logic                    fx_ge0;
      logic                    fx_lt_hi;
      logic                    fx_le_hi;
      logic                    fx_ge_hi;
      logic                    e1_ge0;
      logic                    e1_le0;
      logic                    e1_le_hi;
      logic                    e1_ge_hi;
      logic                    oof_last;
      logic                    oof_past;
   } sb_type;

   logic   a_valid_ff, b_valid_ff, c_valid_ff;
   logic   a_ready, b_ready, c_ready;
   sa_type sa_ff, sa_in;
   sb_type sb_ff, sb_in;
   work_type sc_ff, sc_in;

   logic [SPAN_W-1:0]        n_sat;
   logic signed [SPAN_W:0]   n_s;
   logic signed [PROD_W-1:0] e1, e2, fx_w;
   logic                     neg;
   logic signed [A_W-1:0]    mag_a;
   logic [DEN_W-1:0]         den;
   logic signed [A_W-1:0]    thr [LANES];
   logic [CALC_W-1:0]        num [LANES];
   logic                     direct_mid, direct_low, direct_high;

   assign a_ready   = !a_valid_ff || b_ready;
   assign b_ready   = !b_valid_ff || c_ready;
   assign c_ready   = !c_valid_ff || out_ready;
   assign in_ready  = a_ready;
   assign out_valid = c_valid_ff;
   assign out_data  = sc_ff;

   // stage A: saturate length, n * step
   always_comb begin
      n_sat = (int'(in_data.span_len) > MAX_SPAN) ? SPAN_W'(MAX_SPAN) : in_data.span_len;
      n_s   = signed'({1'b0, n_sat});
      sa_in.n    = n_sat;
      sa_in.fx0  = in_data.start_pos;
      sa_in.dx   = in_data.step_size;
      sa_in.va   = in_data.value_first;
      sa_in.vb   = in_data.value_second;
      sa_in.prod = n_s * $signed(in_data.step_size);
   end

   // stage B: last position and one-past position, compared to the edges
   always_comb begin
      fx_w = PROD_W'($signed(sa_ff.fx0));
      e2   = fx_w + sa_ff.prod;
      e1   = e2 - PROD_W'($signed(sa_ff.dx));
      sb_in.n        = sa_ff.n;
      sb_in.fx0      = sa_ff.fx0;
      sb_in.dx       = sa_ff.dx;
      sb_in.va       = sa_ff.va;
      sb_in.vb       = sa_ff.vb;
      sb_in.fx_le0   = fx_w <= PROD_W'(0);
      sb_in.fx_ge0   = fx_w >= PROD_W'(0);
      sb_in.fx_lt_hi = fx_w < PROD_W'(EDGE_HI);
      sb_in.fx_le_hi = fx_w <= PROD_W'(EDGE_HI);
      sb_in.fx_ge_hi = fx_w >= PROD_W'(EDGE_HI);
      sb_in.e1_ge0   = e1 >= PROD_W'(0);
      sb_in.e1_le0   = e1 <= PROD_W'(0);
      sb_in.e1_le_hi = e1 <= PROD_W'(EDGE_HI);
      sb_in.e1_ge_hi = e1 >= PROD_W'(EDGE_HI);
      sb_in.oof_last = (e1 < PROD_W'(-FIX_MAX)) || (e1 > PROD_W'(FIX_MAX));
      sb_in.oof_past = (e2 < PROD_W'(-FIX_MAX)) || (e2 > PROD_W'(FIX_MAX));
   end

   // stage C: classify, mirror negative steps, set up ceil-divide numerators
   always_comb begin
      neg   = sb_ff.dx[POS_W-1];
      mag_a = neg ? -A_W'($signed(sb_ff.fx0)) : A_W'($signed(sb_ff.fx0));
      den   = neg ? (~sb_ff.dx + 1'b1) : sb_ff.dx;

      thr[LANE_LO]  = neg ? THR_LO_NEG : THR_LO_POS;
      thr[LANE_HI]  = neg ? THR_HI_NEG : THR_HI_POS;
      thr[LANE_LIM] = THR_LIM;

      direct_mid  = sb_ff.fx_ge0 && sb_ff.fx_le_hi && sb_ff.e1_ge0 && sb_ff.e1_le_hi;
      direct_low  = sb_ff.fx_le0 && sb_ff.e1_le0;
      direct_high = sb_ff.fx_ge_hi && sb_ff.e1_ge_hi;

      sc_in.ctx.n   = sb_ff.n;
      sc_in.ctx.fx0 = sb_ff.fx0;
      sc_in.ctx.dx  = sb_ff.dx;
      sc_in.ctx.neg = neg;
      sc_in.ctx.ovf = 1'b0;
      sc_in.den     = den;

      if (sb_ff.n == '0) begin
         sc_in.ctx.run_class = CLASS_NONE;
      end else if (sb_ff.n == SPAN_W'(1)) begin
         if (sb_ff.fx_le0) begin
            sc_in.ctx.run_class = CLASS_LOW;
         end else if (sb_ff.fx_lt_hi) begin
            sc_in.ctx.run_class = CLASS_MID;
         end else begin
            sc_in.ctx.run_class = CLASS_HIGH;
         end
      end else if (direct_mid) begin
         sc_in.ctx.run_class = CLASS_MID;
         sc_in.ctx.ovf       = sb_ff.oof_last;
      end else if (direct_low) begin
         sc_in.ctx.run_class = CLASS_LOW;
         sc_in.ctx.ovf       = sb_ff.oof_last;
      end else if (direct_high) begin
         sc_in.ctx.run_class = CLASS_HIGH;
         sc_in.ctx.ovf       = sb_ff.oof_last;
      end else begin
         sc_in.ctx.run_class = CLASS_SPLIT;
         sc_in.ctx.ovf       = sb_ff.oof_past;
      end

      if (sc_in.ctx.run_class == CLASS_SPLIT && neg) begin
         sc_in.ctx.va = sb_ff.vb;
         sc_in.ctx.vb = sb_ff.va;
      end else begin
         sc_in.ctx.va = sb_ff.va;
         sc_in.ctx.vb = sb_ff.vb;
      end

      // count of i with a + i*d < thr is ceil((thr - a) / d) when a < thr
      for (int j = 0; j < LANES; j++) begin
         if (mag_a < thr[j]) begin
            num[j] = CALC_W'(thr[j]) - CALC_W'(mag_a) + CALC_W'(den) - CALC_W'(1);
         end else begin
            num[j] = '0;
         end
         sc_in.lane[j].rem = num[j][NUM_W-1:0];
         sc_in.lane[j].quo = '0;
         sc_in.lane[j].sat = CMP_W'(num[j][NUM_W-1:0]) >= (CMP_W'(den) << QW);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
         c_valid_ff <= 1'b0;
      end else begin
         if (a_ready) begin
            a_valid_ff <= in_valid;
         end
         if (b_ready) begin
            b_valid_ff <= a_valid_ff;
         end
         if (c_ready) begin
            c_valid_ff <= b_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (a_ready && in_valid) begin
         sa_ff <= sa_in;
      end
      if (b_ready && a_valid_ff) begin
         sb_ff <= sb_in;
      end
      if (c_ready && b_valid_ff) begin
         sc_ff <= sc_in;
      end
   end

endmodule

FILE: sv/gcss_div_cell.sv
// One restoring-division cell: settles one quotient bit for all three lanes.
// Depends on gcss_pkg.
module gcss_div_cell #(
   parameter int BIT = 0
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   output logic               in_ready,
   input  gcss_pkg::work_type in_data,
   output logic               out_valid,
   input  logic               out_ready,
   output gcss_pkg::work_type out_data
);
   import gcss_pkg::*;

   logic             valid_ff;
   work_type         work_ff, work_in;
   logic [CMP_W-1:0] shifted;
   logic [CMP_W-1:0] rem_ext;

   assign in_ready  = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign out_data  = work_ff;

   always_comb begin
      work_in = in_data;
      shifted = CMP_W'(in_data.den) << BIT;
      rem_ext = '0;
      for (int j = 0; j < LANES; j++) begin
         rem_ext = CMP_W'(in_data.lane[j].rem);
         if (rem_ext >= shifted) begin
            work_in.lane[j].rem      = NUM_W'(rem_ext - shifted);
            work_in.lane[j].quo[BIT] = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         work_ff <= work_in;
      end
   end

endmodule

FILE: sv/gcss_post.sv
// Back end: clamps the lane counts, forms the three runs, the middle start
// position and the result register (two stages). Depends on gcss_pkg.
module gcss_post (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   output logic               in_ready,
   input  gcss_pkg::work_type in_data,
   output logic               out_valid,
   input  logic               out_ready,
   output gcss_pkg::rsp_type  out_data
);
   import gcss_pkg::*;

   typedef struct packed {
      logic [SPAN_W-1:0]       run_low;
      logic [SPAN_W-1:0]       run_mid;
      logic [SPAN_W-1:0]       run_high;
      logic signed [POS_W-1:0] fx0;
      logic [POS_W-1:0]        mid_base;
      logic [VAL_W-1:0]        va;
      logic [VAL_W-1:0]        vb;
      logic                    ovf;
   } sd_type;

   logic    d_valid_ff, e_valid_ff;
   logic    d_ready, e_ready;
   sd_type  sd_ff, sd_in;
   rsp_type se_ff, se_in;
   logic [SPAN_W-1:0] lim [LANES];
   logic [SPAN_W-1:0] n;

   assign d_ready   = !d_valid_ff || e_ready;
   assign e_ready   = !e_valid_ff || out_ready;
   assign in_ready  = d_ready;
   assign out_valid = e_valid_ff;
   assign out_data  = se_ff;

   // stage D: runs and the offset of the first middle pixel
   always_comb begin
      n = in_data.ctx.n;
      for (int j = 0; j < LANES; j++) begin
         if (in_data.lane[j].sat || in_data.lane[j].quo > n) begin
            lim[j] = n;
         end else begin
            lim[j] = in_data.lane[j].quo;
         end
      end

      sd_in.fx0      = in_data.ctx.fx0;
      sd_in.va       = in_data.ctx.va;
      sd_in.vb       = in_data.ctx.vb;
      sd_in.ovf      = in_data.ctx.ovf;
      sd_in.run_low  = '0;
      sd_in.run_mid  = '0;
      sd_in.run_high = '0;
      sd_in.mid_base = '0;

      case (in_data.ctx.run_class)
         CLASS_LOW: begin
            sd_in.run_low = n;
         end
         CLASS_MID: begin
            sd_in.run_mid = n;
         end
         CLASS_HIGH: begin
            sd_in.run_high = n;
         end
         CLASS_SPLIT: begin
            // pixels past the range limit join the trailing run of the walk
            if (in_data.ctx.neg) begin
               sd_in.run_low  = lim[LANE_LO] + (n - lim[LANE_LIM]);
               sd_in.run_high = lim[LANE_LIM] - lim[LANE_HI];
            end else begin
               sd_in.run_low  = lim[LANE_LO];
               sd_in.run_high = n - lim[LANE_HI];
            end
            sd_in.run_mid  = lim[LANE_HI] - lim[LANE_LO];
            sd_in.mid_base = POS_W'(POS_W'(lim[LANE_LO]) * unsigned'(in_data.ctx.dx));
         end
         default: begin
            sd_in.run_low = '0;
         end
      endcase
   end

   // stage E: result register
   always_comb begin
      se_in.run_low       = sd_ff.run_low;
      se_in.run_mid       = sd_ff.run_mid;
      se_in.run_high      = sd_ff.run_high;
      se_in.end_value_a   = sd_ff.va;
      se_in.end_value_b   = sd_ff.vb;
      se_in.overflow_flag = sd_ff.ovf;
      if (sd_ff.run_mid == '0) begin
         se_in.mid_start = '0;
      end else begin
         se_in.mid_start = sd_ff.fx0 + signed'(sd_ff.mid_base);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         d_valid_ff <= 1'b0;
         e_valid_ff <= 1'b0;
      end else begin
         if (d_ready) begin
            d_valid_ff <= in_valid;
         end
         if (e_ready) begin
            e_valid_ff <= d_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (d_ready && in_valid) begin
         sd_ff <= sd_in;
      end
      if (e_ready && d_valid_ff) begin
         se_ff <= se_in;
      end
   end

endmodule

FILE: sim/gradient_clamp_span_split_top_tb.sv
// Testbench for the gradient clamp span splitter: directed and random spans
// checked item by item against a local predictor. Depends on gcss_pkg and the top.
`timescale 1ns / 1ps

module gradient_clamp_span_split_top_tb;
   import gcss_pkg::*;

   localparam longint FIX_LIM  = 64'sh7FFFFFFF;
   localparam longint EDGE     = 64'shFFFF;
   localparam int     WD_LIMIT = 20000;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   rsp_type span_q[$];     // expected results, oldest first
   int      send_idle = 0;  // percent of cycles the sender holds off
   int      recv_idle = 0;  // percent of cycles the receiver stalls
   int      errors = 0;
   int      idle_cycles = 0;

   gradient_clamp_span_split_top DUT (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data)
   );

   always #5 clock = ~clock;

   // pixels (<= n) whose position stays below lim, step positive
   function automatic longint count_below(longint x0, longint lim, longint x1,
                                          longint d, longint n);
      if (x0 >= lim) return 0;
      if (x1 <= lim) return n;
      return (lim - x0 + d - 1) / d;
   endfunction

   function automatic logic out_of_range(longint x);
      return (x < -FIX_LIM) || (x > FIX_LIM);
   endfunction

   // expected split of one span
   function automatic rsp_type split_span(req_type r);
      rsp_type o;
      longint  fx0, fx, dx, n, ex, lo, md, hi, extra, mid, cnt, adx, afx, k, t;
      logic    ovf, neg;
      logic [VAL_W-1:0] va, vb, u;
      logic [31:0] p;
      fx0 = longint'(r.start_pos);
      dx  = longint'(r.step_size);
      n   = longint'(r.span_len);
      va  = r.value_first;
      vb  = r.value_second;
      lo = 0; md = 0; hi = 0; extra = 0; mid = 0; ovf = 1'b0;
      if (n > MAX_SPAN_DEF) n = MAX_SPAN_DEF;
      if (n == 1) begin
         if (fx0 <= 0) lo = 1;
         else if (fx0 < EDGE) begin
            md = 1; mid = fx0;
         end else hi = 1;
      end else if (n > 1) begin
         fx = fx0;
         ex = fx + (n - 1) * dx;
         ovf = out_of_range(ex);
         if (fx >= 0 && fx <= EDGE && ex >= 0 && ex <= EDGE) begin
            md = n; mid = fx0;
         end else if (fx <= 0 && ex <= 0) lo = n;
         else if (fx >= EDGE && ex >= EDGE) hi = n;
         else begin
            neg = dx < 0;
            cnt = n;
            ex += dx;
            ovf = out_of_range(ex);
            // span crosses the range limit: split only the part before it
            if (ovf) begin
               adx = neg ? -dx : dx;
               afx = neg ? -fx : fx;
               k = (FIX_LIM - afx + adx - 1) / adx;
               if (k < 0) k = 0;
               if (k > cnt) k = cnt;
               extra = cnt - k;
               cnt = k;
               ex = fx + dx * cnt;
            end
            if (neg) begin
               t = ex - dx; ex = fx - dx; fx = t; dx = -dx;
            end
            lo = count_below(fx, 0, ex, dx, cnt);
            cnt -= lo;
            fx += lo * dx;
            md = count_below(fx, EDGE, ex, dx, cnt);
            cnt -= md;
            hi = cnt;
            if (neg) begin
               t = lo; lo = hi; hi = t;
               u = va; va = vb; vb = u;
               dx = -dx;
            end
            if (md > 0) begin
               p = 32'(fx0) + 32'(lo) * 32'(dx);
               mid = longint'(p);
            end
            if (dx > 0) hi += extra;
            else lo += extra;
         end
      end
      if (md == 0) mid = 0;
      o.run_low       = lo[SPAN_W-1:0];
      o.run_mid       = md[SPAN_W-1:0];
      o.run_high      = hi[SPAN_W-1:0];
      o.mid_start     = mid[31:0];
      o.end_value_a   = va;
      o.end_value_b   = vb;
      o.overflow_flag = ovf;
      return o;
   endfunction

   // send one span; valid stays up between back-to-back items
   task automatic send_span(input logic [31:0] sp, input logic [31:0] st,
                            input logic [SPAN_W-1:0] len);
      req_type r;
      r.start_pos    = sp;
      r.step_size    = st;
      r.span_len     = len;
      r.value_first  = $urandom;
      r.value_second = $urandom;
      if ($urandom_range(99) < send_idle) begin
         req_valid <= 1'b0;
         @(posedge clock);
         while ($urandom_range(99) < send_idle) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= r;
      do @(posedge clock); while (!req_ready);
      span_q.push_back(split_span(r));
   endtask

   // hold the sender off until every result is back
   task automatic drain_all();
      req_valid <= 1'b0;
      @(posedge clock);
      while (span_q.size() != 0) @(posedge clock);
   endtask

   // result checker and receiver stall
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (span_q.size() == 0) begin
               errors++;
               if (errors <= 10) $display("unexpected result item %p", rsp_data);
            end else begin
               if (rsp_data !== span_q[0]) begin
                  errors++;
                  if (errors <= 10)
                     $display("mismatch: expected %p got %p", span_q[0], rsp_data);
               end
               void'(span_q.pop_front());
            end
         end
         rsp_ready <= ($urandom_range(99) >= recv_idle);
      end
   end

   // watchdog on cycles with no item accepted on either side
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WD_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   task automatic test_single_pixel();
      send_span(32'h0, 32'h1, 13'd1);
      send_span(32'hFFFFFFFF, 32'h0, 13'd1);
      send_span(32'h1, 32'h0, 13'd1);
      send_span(32'hFFFE, 32'h0, 13'd1);
      send_span(32'hFFFF, 32'h0, 13'd1);
      send_span(32'h7FFFFFFF, 32'h80000000, 13'd1);
      send_span(32'h80000000, 32'h7FFFFFFF, 13'd1);
   endtask

   task automatic test_whole_span();
      send_span(32'h0, 32'h10, 13'd16);            // all inside
      send_span(32'hFFFFF000, 32'h1, 13'd100);     // all low
      send_span(32'h20000, 32'h100, 13'd50);       // all high
      send_span(32'h7FFF0000, 32'h10000, 13'd4096);// all high, overflow
      send_span(32'h80000000, 32'hFFFF0000, 13'd20);
      send_span(32'h0, 32'h0, 13'd0);              // zero length
      send_span(32'h1234, 32'h1, 13'd8191);        // long, saturated
   endtask

   task automatic test_split();
      send_span(32'hFFFF8000, 32'h400, 13'd200);   // low into mid into high
      send_span(32'h18000, 32'hFFFFFC00, 13'd200); // reversed
      send_span(32'h8000, 32'h7FFFFFFF, 13'd4);    // overflow positive
      send_span(32'h8000, 32'h80000001, 13'd4);    // overflow negative
      send_span(32'h80000000, 32'h7FFFFFFF, 13'd3);
      send_span(32'h7FFFFFFF, 32'h80000000, 13'd3);
      send_span(32'hFFFFFFFF, 32'h10000, 13'd2);   // empty middle
      send_span(32'h10000, 32'hFFFF0000, 13'd2);
      send_span(32'hFFFFFFFF, 32'h1, 13'd4096);
   endtask

   task automatic test_random(input int count);
      logic [31:0] sp, st;
      logic [SPAN_W-1:0] len;
      for (int i = 0; i < count; i++) begin
         len = SPAN_W'($urandom_range(2, 64));
         case ($urandom_range(9))
            0, 1, 2: begin  // crossing one or both edges
               sp = $urandom_range(32'h30000) - 32'h18000;
               st = $urandom_range(32'h2000) - 32'h1000;
            end
            3, 4: begin  // small step, mostly inside
               sp = $urandom_range(32'hFFFF);
               st = $urandom_range(64) - 32;
            end
            5: begin  // huge step, overflow tails
               sp = $urandom;
               st = $urandom_range(1) ? 32'h7FFF0000 + $urandom_range(32'hFFFF)
                                      : 32'h80000000 + $urandom_range(32'hFFFF);
               len = SPAN_W'($urandom_range(2, 8));
            end
            6: begin  // single pixel or empty
               sp = $urandom_range(32'h20000) - 32'h8000;
               st = $urandom;
               len = SPAN_W'($urandom_range(1));
            end
            7: begin  // long spans
               sp = $urandom_range(32'h20000) - 32'h8000;
               st = $urandom_range(64) - 32;
               len = SPAN_W'($urandom_range(1000, 8191));
            end
            default: begin  // noise
               sp = $urandom;
               st = $urandom;
               len = SPAN_W'($urandom);
            end
         endcase
         send_span(sp, st, len);
      end
   endtask

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_single_pixel();
      test_whole_span();
      test_split();
      drain_all();
      send_idle = 0;  recv_idle = 0;  test_random(500);
      send_idle = 73; recv_idle = 0;  test_random(450);
      drain_all();
      send_idle = 0;  recv_idle = 73; test_random(500);
      send_idle = 27; recv_idle = 27; test_random(477);
      drain_all();
      repeat (40) @(posedge clock);
      if (errors == 0 && span_q.size() == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
